// ----- hdl/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types for the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

   // per-cell update control, driven by the top level
   typedef struct packed {
      logic load;         // a new sample beat enters the chain this cycle
      logic evict_below;  // the evicted cell sits at a lower position
   } cell_ctrl_type;

endpackage

// ----- hdl/smf_req_if.sv -----
// ----------------------------------------------------------------------------
// smf_req_if
// Sample input channel: valid/ready handshake with one sample per beat.
// ----------------------------------------------------------------------------
interface smf_req_if #(
   parameter int WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

// ----- hdl/smf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// smf_rsp_if
// Result channel: valid/ready handshake with one filtered value per beat.
// ----------------------------------------------------------------------------
interface smf_rsp_if #(
   parameter int WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] filtered_value;
   logic                    published;

   modport source (output valid, output filtered_value, output published, input ready);
   modport sink   (input valid, input filtered_value, input published, output ready);
endinterface

// ----- hdl/sliding_median_filter.sv -----
// ----------------------------------------------------------------------------
// sliding_median_filter
// Sliding-window median: a sorted chain of cells, one slot per window entry,
// drops the oldest sample and inserts the new one each beat.
// ----------------------------------------------------------------------------
// Path: an accepted sample beat is registered in the cell chain, and the
// output register then averages the two middle cells into its result beat.
// Throughput: 1 beat per cycle unless the result sink stalls the output.
// Reset: synchronous; the window clears to zero, publish_ff to zero.
// ----------------------------------------------------------------------------
module sliding_median_filter #(
   parameter int WINDOW       = 8,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   smf_req_if.sink   req_chan,
   smf_rsp_if.source rsp_chan,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   localparam int AGE_W   = $clog2(WINDOW);
   localparam int LO_RANK = WINDOW / 2 - 1;
   localparam int HI_RANK = WINDOW / 2;

   logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW];
   logic [AGE_W-1:0]               cell_age   [WINDOW];
   logic [WINDOW-1:0]              cell_le;
   logic [WINDOW-1:0]              cell_evict;
   logic [WINDOW-1:0]              evict_below;

   logic pend_ff, pend_in;
   logic publish_ff, publish_in;
   logic load;
   logic accept;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !pend_ff || load;

   assign pend_in    = accept ? 1'b1 : (load ? 1'b0 : pend_ff);
   assign publish_in = csr_we ? csr_wdata : publish_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         publish_ff <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         publish_ff <= publish_in;
      end
   end

   assign evict_below[0] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < WINDOW; i++) begin : g_cell
         smf_pkg::cell_ctrl_type         ctrl;
         logic signed [SAMPLE_WIDTH-1:0] lower_value;
         logic [AGE_W-1:0]               lower_age;
         logic                           lower_le;
         logic signed [SAMPLE_WIDTH-1:0] upper_value;
         logic [AGE_W-1:0]               upper_age;
         logic                           upper_le;

         assign ctrl.load        = accept;
         assign ctrl.evict_below = evict_below[i];
         assign cell_evict[i]    = (cell_age[i] == AGE_W'(WINDOW - 1));

         if (i < WINDOW - 1) begin : g_chain
            assign evict_below[i+1] = evict_below[i] | cell_evict[i];
         end

         if (i == 0) begin : g_first
            assign lower_value = '0;
            assign lower_age   = '0;
            assign lower_le    = 1'b1;
         end else begin : g_lower
            assign lower_value = cell_value[i-1];
            assign lower_age   = cell_age[i-1];
            assign lower_le    = cell_le[i-1];
         end

         if (i == WINDOW - 1) begin : g_last
            assign upper_value = '0;
            assign upper_age   = '0;
            assign upper_le    = 1'b0;
         end else begin : g_upper
            assign upper_value = cell_value[i+1];
            assign upper_age   = cell_age[i+1];
            assign upper_le    = cell_le[i+1];
         end

         smf_cell #(
            .WIDTH     (SAMPLE_WIDTH),
            .AGE_W     (AGE_W),
            .RESET_AGE (WINDOW - 1 - i)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (req_chan.sample_value),
            .lower_value (lower_value),
            .lower_age   (lower_age),
            .lower_le    (lower_le),
            .upper_value (upper_value),
            .upper_age   (upper_age),
            .upper_le    (upper_le),
            .value       (cell_value[i]),
            .age         (cell_age[i]),
            .le          (cell_le[i]),
            .evict       (cell_evict[i])
         );
      end
   endgenerate

   smf_out #(
      .WIDTH (SAMPLE_WIDTH)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .pending  (pend_ff),
      .publish  (publish_ff),
      .lo_value (cell_value[LO_RANK]),
      .hi_value (cell_value[HI_RANK]),
      .load     (load),
      .rsp      (rsp_chan)
   );

`ifndef SYNTH
   a_one_oldest : assert property (@(posedge clock) disable iff (reset)
      $onehot(cell_evict))
      else $error("window must hold exactly one oldest entry");

   a_accept_pends : assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff)
      else $error("accepted sample did not mark a pending result");

   a_pend_kept : assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !load) |=> pend_ff)
      else $error("pending result dropped without loading output");

   a_mid_sorted : assert property (@(posedge clock) disable iff (reset)
      cell_value[LO_RANK] <= cell_value[HI_RANK])
      else $error("middle ranks out of order");
`endif

endmodule

// ----- hdl/smf_cell.sv -----
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window. Holds a sample and its age; on each beat it
// keeps its value, takes a neighbor's, or takes the new sample.
// ----------------------------------------------------------------------------
module smf_cell #(
   parameter int WIDTH     = 32,
   parameter int AGE_W     = 3,
   parameter int RESET_AGE = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  smf_pkg::cell_ctrl_type  ctrl,
   input  logic signed [WIDTH-1:0] new_value,
   input  logic signed [WIDTH-1:0] lower_value,
   input  logic [AGE_W-1:0]        lower_age,
   input  logic                    lower_le,
   input  logic signed [WIDTH-1:0] upper_value,
   input  logic [AGE_W-1:0]        upper_age,
   input  logic                    upper_le,
   output logic signed [WIDTH-1:0] value,
   output logic [AGE_W-1:0]        age,
   output logic                    le,
   input  logic                    evict
);

   logic signed [WIDTH-1:0] value_ff, value_in;
   logic [AGE_W-1:0]        age_ff, age_in;
   logic                    prev_le;
   logic signed [WIDTH-1:0] prev_value;
   logic [AGE_W-1:0]        prev_age;

   assign value = value_ff;
   assign age   = age_ff;
   assign le    = (value_ff <= new_value);

   always_comb begin
      prev_le    = ctrl.evict_below ? le       : lower_le;
      prev_value = ctrl.evict_below ? value_ff : lower_value;
      prev_age   = ctrl.evict_below ? age_ff   : lower_age;
      value_in   = value_ff;
      age_in     = age_ff;
      if (ctrl.load) begin
         if (!ctrl.evict_below && !evict) begin
            if (le) begin
               value_in = value_ff;
               age_in   = age_ff + AGE_W'(1);
            end else if (lower_le) begin
               value_in = new_value;
               age_in   = '0;
            end else begin
               value_in = lower_value;
               age_in   = lower_age + AGE_W'(1);
            end
         end else begin
            if (upper_le) begin
               value_in = upper_value;
               age_in   = upper_age + AGE_W'(1);
            end else if (prev_le) begin
               value_in = new_value;
               age_in   = '0;
            end else begin
               value_in = prev_value;
               age_in   = prev_age + AGE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         age_ff   <= AGE_W'(RESET_AGE);
      end else begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

// ----- hdl/smf_out.sv -----
// ----------------------------------------------------------------------------
// smf_out
// Output register: averages the two middle ranks with floor rounding and
// holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module smf_out #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pending,
   input  logic                    publish,
   input  logic signed [WIDTH-1:0] lo_value,
   input  logic signed [WIDTH-1:0] hi_value,
   output logic                    load,
   smf_rsp_if.source               rsp
);

   logic                    valid_ff, valid_in;
   logic signed [WIDTH-1:0] mean_ff, mean_in;
   logic                    pub_ff, pub_in;
   logic signed [WIDTH:0]   sum;

   assign sum     = {lo_value[WIDTH-1], lo_value} + {hi_value[WIDTH-1], hi_value};
   assign load    = pending && (!valid_ff || rsp.ready);
   assign mean_in = load ? sum[WIDTH:1] : mean_ff;
   assign pub_in  = load ? publish : pub_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mean_ff <= mean_in;
      pub_ff  <= pub_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.filtered_value = mean_ff;
   assign rsp.published      = pub_ff;

endmodule
